// ===== rtl/ftc_pkg.sv =====
`timescale 1ns / 1ps

package ftc_pkg;

   localparam int DepthDefault    = 512;
   localparam int ChannelsDefault = 8;
   localparam int LaneCount       = 8;

   localparam int ValueW = 24;
   localparam int WordW  = 16;
   localparam int SlotW  = 9;
   localparam int LimitW = 12;

   localparam logic [LimitW-1:0] LimitReset = 12'd3270;
   localparam int                WordMax    = 32767;

   typedef struct packed {
      logic signed [ValueW-1:0] ch0_value;
      logic signed [ValueW-1:0] ch1_value;
      logic signed [ValueW-1:0] ch2_value;
      logic signed [ValueW-1:0] ch3_value;
      logic signed [ValueW-1:0] ch4_value;
      logic signed [ValueW-1:0] ch5_value;
      logic signed [ValueW-1:0] ch6_value;
      logic signed [ValueW-1:0] ch7_value;
      logic                     heavy_fault;
   } ftc_req_type;

   typedef struct packed {
      logic                    stored;
      logic                    to_post;
      logic [SlotW-1:0]        slot;
      logic                    capture_done;
      logic signed [WordW-1:0] word0;
      logic signed [WordW-1:0] word1;
      logic signed [WordW-1:0] word2;
      logic signed [WordW-1:0] word3;
      logic signed [WordW-1:0] word4;
      logic signed [WordW-1:0] word5;
      logic signed [WordW-1:0] word6;
      logic signed [WordW-1:0] word7;
   } ftc_rsp_type;

   typedef struct packed {
      logic             stored;
      logic             to_post;
      logic [SlotW-1:0] slot;
      logic             capture_done;
   } ftc_slot_type;

endpackage

// ===== rtl/ftc_lane.sv =====
`timescale 1ns / 1ps

module ftc_lane import ftc_pkg::*; (
   input  logic signed [ValueW-1:0] value,
   input  logic [LimitW-1:0]        limit,
   output logic signed [WordW-1:0]  word
);

   localparam int RawW  = ValueW + 1;
   localparam int ProdW = RawW + 4;
   localparam int QuotW = ProdW - 8;

   logic signed [RawW-1:0]  raw;
   logic signed [RawW-1:0]  lim_pos;
   logic signed [RawW-1:0]  lim_neg;
   logic signed [RawW-1:0]  clamped;
   logic signed [ProdW-1:0] wide;
   logic signed [ProdW-1:0] biased;
   logic [ProdW-1:0]        mag;
   logic [QuotW-1:0]        quot;
   logic [WordW-1:0]        sat;

   always_comb begin
      raw     = RawW'(value);
      lim_pos = $signed({{(RawW-LimitW-8){1'b0}}, limit, 8'h00});
      lim_neg = -lim_pos;
      if (raw > lim_pos) begin
         clamped = lim_pos;
      end else if (raw < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = raw;
      end
      // 10*r + 0.5 in 1/256 units, then truncate toward zero
      wide   = ProdW'(clamped);
      biased = (wide <<< 3) + (wide <<< 1) + ProdW'(128);
      mag    = biased[ProdW-1] ? ProdW'(-biased) : ProdW'(biased);
      quot   = mag[ProdW-1:8];
      if (quot > QuotW'(WordMax)) begin
         sat = WordW'(WordMax);
      end else begin
         sat = quot[WordW-1:0];
      end
      word = biased[ProdW-1] ? $signed(-sat) : $signed(sat);
   end

endmodule

// ===== rtl/ftc_slot_ctrl.sv =====
`timescale 1ns / 1ps

module ftc_slot_ctrl import ftc_pkg::*; #(
   parameter int DEPTH = DepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         heavy_fault,
   output ftc_slot_type info
);

   localparam int CntW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CntW-1:0] LastSlot = CntW'(DEPTH - 1);

   logic [CntW-1:0] pre_slot_ff, pre_slot_in;
   logic [CntW-1:0] post_slot_ff, post_slot_in;
   logic            stopped_ff, stopped_in;

   always_comb begin
      pre_slot_in  = pre_slot_ff;
      post_slot_in = post_slot_ff;
      stopped_in   = stopped_ff;
      info.stored  = 1'b1;
      info.to_post = heavy_fault;
      if (heavy_fault) begin
         info.slot = SlotW'(post_slot_ff);
         if (stopped_ff) begin
            info.stored = 1'b0;
         end else if (post_slot_ff == LastSlot) begin
            post_slot_in = '0;
            stopped_in   = 1'b1;
         end else begin
            post_slot_in = post_slot_ff + 1'b1;
         end
      end else begin
         info.slot   = SlotW'(pre_slot_ff);
         pre_slot_in = (pre_slot_ff == LastSlot) ? '0 : pre_slot_ff + 1'b1;
      end
      info.capture_done = stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_slot_ff  <= '0;
         post_slot_ff <= '0;
         stopped_ff   <= 1'b0;
      end else if (advance) begin
         pre_slot_ff  <= pre_slot_in;
         post_slot_ff <= post_slot_in;
         stopped_ff   <= stopped_in;
      end
   end

endmodule

// ===== rtl/fault_trace_capture.sv =====
`timescale 1ns / 1ps

// Fault trace capture front end. Each request transaction carries one sample
// tick of eight signed channel values and the heavy fault flag; each produces
// exactly one response transaction with the clamped, scaled words and the
// store slot they belong in (pre-fault ring, or post-fault store until it has
// filled once, after which fault ticks report stored = 0). The response feeds
// the trace store memories, banked one per channel. A transaction is taken
// every cycle unless req_stall is high, and passes through the input register
// and the result register around the per-channel clamp/scale lanes. rsp_stall
// reaches req_stall through the same cycle. The user must write the clamp
// limit through the csr port while no transaction is in flight; unenforced.

module fault_trace_capture import ftc_pkg::*; #(
   parameter int DEPTH    = DepthDefault,
   parameter int CHANNELS = ChannelsDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ftc_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ftc_rsp_type       rsp_payload,
   input  logic              csr_write_enable,
   input  logic [LimitW-1:0] csr_write_data
);

   logic [LimitW-1:0] limit_ff;
   logic              s1_valid_ff;
   ftc_req_type       s1_req_ff;
   logic              rsp_valid_ff;
   ftc_rsp_type       rsp_ff, rsp_in;
   logic              out_ready;
   logic              s1_ready;
   logic              advance;
   ftc_slot_type      slot_info;

   logic signed [ValueW-1:0] ch_value [LaneCount];
   logic signed [WordW-1:0]  ch_word  [LaneCount];

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign req_stall = !s1_ready;

   assign ch_value[0] = s1_req_ff.ch0_value;
   assign ch_value[1] = s1_req_ff.ch1_value;
   assign ch_value[2] = s1_req_ff.ch2_value;
   assign ch_value[3] = s1_req_ff.ch3_value;
   assign ch_value[4] = s1_req_ff.ch4_value;
   assign ch_value[5] = s1_req_ff.ch5_value;
   assign ch_value[6] = s1_req_ff.ch6_value;
   assign ch_value[7] = s1_req_ff.ch7_value;

   for (genvar i = 0; i < LaneCount; i++) begin : g_lane
      if (i < CHANNELS) begin : g_used
         ftc_lane u_lane (
            .value (ch_value[i]),
            .limit (limit_ff),
            .word  (ch_word[i])
         );
      end else begin : g_unused
         assign ch_word[i] = '0;
      end
   end

   ftc_slot_ctrl #(
      .DEPTH (DEPTH)
   ) u_slot_ctrl (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .heavy_fault (s1_req_ff.heavy_fault),
      .info        (slot_info)
   );

   always_comb begin
      rsp_in.stored       = slot_info.stored;
      rsp_in.to_post      = slot_info.to_post;
      rsp_in.slot         = slot_info.slot;
      rsp_in.capture_done = slot_info.capture_done;
      rsp_in.word0        = slot_info.stored ? ch_word[0] : '0;
      rsp_in.word1        = slot_info.stored ? ch_word[1] : '0;
      rsp_in.word2        = slot_info.stored ? ch_word[2] : '0;
      rsp_in.word3        = slot_info.stored ? ch_word[3] : '0;
      rsp_in.word4        = slot_info.stored ? ch_word[4] : '0;
      rsp_in.word5        = slot_info.stored ? ch_word[5] : '0;
      rsp_in.word6        = slot_info.stored ? ch_word[6] : '0;
      rsp_in.word7        = slot_info.stored ? ch_word[7] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LimitReset;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) begin
         s1_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/ftc_checker.sv =====
`timescale 1ns / 1ps

module ftc_checker import ftc_pkg::*; #(
   parameter int DEPTH = DepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  ftc_req_type       req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  ftc_rsp_type       rsp_payload,
   input  logic              csr_write_enable,
   input  logic [LimitW-1:0] csr_write_data,
   output int                pending,
   output int                failures
);

   ftc_rsp_type       tick_q[$];
   ftc_rsp_type       want;
   int unsigned       pre_idx;
   int unsigned       post_idx;
   logic              post_full;
   logic [LimitW-1:0] limit;
   int                mismatches = 0;

   assign failures = mismatches;

   function automatic logic signed [WordW-1:0] scale_sample(logic signed [ValueW-1:0] v,
                                                            logic [LimitW-1:0] lim);
      longint r;
      longint bound;
      longint t;
      longint w;
      r = longint'(v);
      bound = longint'(lim) * 256;
      if (r > bound) r = bound;
      else if (r < -bound) r = -bound;
      t = r * 10 + 128;
      if (t >= 0) w = t / 256;
      else w = -((-t) / 256);
      if (w > WordMax) w = WordMax;
      if (w < -WordMax) w = -WordMax;
      return w[WordW-1:0];
   endfunction

   function automatic ftc_rsp_type predict_tick(ftc_req_type t);
      ftc_rsp_type             res;
      logic signed [ValueW-1:0] vals [LaneCount];
      logic signed [WordW-1:0]  words [LaneCount];
      int unsigned             idx;
      vals = '{t.ch0_value, t.ch1_value, t.ch2_value, t.ch3_value,
               t.ch4_value, t.ch5_value, t.ch6_value, t.ch7_value};
      res = '0;
      // post-fault store already filled: nothing written
      if (t.heavy_fault && post_full) begin
         res.to_post = 1'b1;
         res.slot = post_idx[SlotW-1:0];
         res.capture_done = 1'b1;
         return res;
      end
      idx = t.heavy_fault ? post_idx : pre_idx;
      if (idx >= DEPTH) idx = 0;
      for (int c = 0; c < LaneCount; c++) words[c] = scale_sample(vals[c], limit);
      res.word0 = words[0];
      res.word1 = words[1];
      res.word2 = words[2];
      res.word3 = words[3];
      res.word4 = words[4];
      res.word5 = words[5];
      res.word6 = words[6];
      res.word7 = words[7];
      res.stored = 1'b1;
      res.to_post = t.heavy_fault;
      res.slot = idx[SlotW-1:0];
      idx++;
      if (t.heavy_fault) begin
         if (idx >= DEPTH) begin
            idx = 0;
            post_full = 1'b1;
         end
         post_idx = idx;
      end else begin
         if (idx >= DEPTH) idx = 0;
         pre_idx = idx;
      end
      res.capture_done = post_full;
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < 100) $display("%0t ftc_checker: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_v);
      if (got !== exp_v)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp_v));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         tick_q.delete();
         pre_idx = 0;
         post_idx = 0;
         post_full = 1'b0;
         limit = LimitReset;
      end else begin
         if (csr_write_enable) limit = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (tick_q.size() == 0) begin
               report_mismatch("response transaction with nothing outstanding");
            end else begin
               want = tick_q.pop_front();
               check_field("stored", 32'(rsp_payload.stored), 32'(want.stored));
               check_field("to_post", 32'(rsp_payload.to_post), 32'(want.to_post));
               check_field("slot", 32'(rsp_payload.slot), 32'(want.slot));
               check_field("capture_done", 32'(rsp_payload.capture_done),
                           32'(want.capture_done));
               check_field("word0", 32'(rsp_payload.word0), 32'(want.word0));
               check_field("word1", 32'(rsp_payload.word1), 32'(want.word1));
               check_field("word2", 32'(rsp_payload.word2), 32'(want.word2));
               check_field("word3", 32'(rsp_payload.word3), 32'(want.word3));
               check_field("word4", 32'(rsp_payload.word4), 32'(want.word4));
               check_field("word5", 32'(rsp_payload.word5), 32'(want.word5));
               check_field("word6", 32'(rsp_payload.word6), 32'(want.word6));
               check_field("word7", 32'(rsp_payload.word7), 32'(want.word7));
            end
         end
         if (req_valid && !req_stall) tick_q.push_back(predict_tick(req_payload));
      end
      pending <= tick_q.size();
   end

endmodule

// ===== tb/tb_fault_trace_capture.sv =====
`timescale 1ns / 1ps

module tb_fault_trace_capture;
   import ftc_pkg::*;

   localparam int QuietLimit = 4000;
   localparam int PhaseItems = 54;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   ftc_req_type       req_payload;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ftc_rsp_type       rsp_payload;
   logic              csr_write_enable;
   logic [LimitW-1:0] csr_write_data;

   int pending;
   int failures;
   int idle_pct;
   int stall_pct;
   int cur_limit;
   int quiet_cycles;

   fault_trace_capture DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   ftc_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .pending         (pending),
      .failures        (failures)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("tb_fault_trace_capture: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic ftc_req_type lane_tick(int v0, int v1, int v2, int v3,
                                             int v4, int v5, int v6, int v7, logic f);
      ftc_req_type t;
      t.ch0_value = v0[ValueW-1:0];
      t.ch1_value = v1[ValueW-1:0];
      t.ch2_value = v2[ValueW-1:0];
      t.ch3_value = v3[ValueW-1:0];
      t.ch4_value = v4[ValueW-1:0];
      t.ch5_value = v5[ValueW-1:0];
      t.ch6_value = v6[ValueW-1:0];
      t.ch7_value = v7[ValueW-1:0];
      t.heavy_fault = f;
      return t;
   endfunction

   function automatic ftc_req_type fill_tick(int v, logic f);
      return lane_tick(v, v, v, v, v, v, v, v, f);
   endfunction

   function automatic int pick_sample(int lim);
      int bound;
      int v;
      bound = lim * 256;
      case ($urandom_range(7))
         0: v = $urandom;
         1: v = bound + int'($urandom_range(600)) - 300;
         2: v = -bound + int'($urandom_range(600)) - 300;
         3: v = int'($urandom_range(2000)) - 1000;
         4: v = 8388607;
         5: v = -8388608;
         default: v = int'($urandom_range(2 * bound + 1024)) - bound - 512;
      endcase
      return v;
   endfunction

   function automatic ftc_req_type random_tick(int lim, logic f);
      return lane_tick(pick_sample(lim), pick_sample(lim), pick_sample(lim),
                       pick_sample(lim), pick_sample(lim), pick_sample(lim),
                       pick_sample(lim), pick_sample(lim), f);
   endfunction

   function automatic ftc_req_type noise_tick();
      return lane_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, 1'($urandom_range(1)));
   endfunction

   task automatic send_tick(ftc_req_type t);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off until every response has come back
   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(int v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v[LimitW-1:0];
      cur_limit = v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int   sent;
      int   len;
      logic fault;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_enable = 1'b0;
      csr_write_data = LimitReset;
      idle_pct = 0;
      stall_pct = 0;
      cur_limit = LimitReset;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset limit, field extremes, clamp edges, rounding edges
      send_tick(fill_tick(0, 1'b0));
      send_tick(fill_tick(8388607, 1'b0));
      send_tick(fill_tick(-8388608, 1'b1));
      send_tick(fill_tick(3270 * 256, 1'b0));
      send_tick(fill_tick(3270 * 256 + 1, 1'b1));
      send_tick(fill_tick(-3270 * 256, 1'b0));
      send_tick(fill_tick(-3270 * 256 - 1, 1'b0));
      send_tick(lane_tick(12, 13, -13, -38, -39, 255, -256, 1, 1'b0));
      send_tick(lane_tick(12, 13, -13, -38, -39, 255, -256, 1, 1'b1));
      send_tick(lane_tick(8388607, -8388608, 0, -1, 8388607, -8388608, 1, -1, 1'b1));
      drain_pipe();
      // limit past the 16-bit word range
      write_limit(4095);
      send_tick(fill_tick(8388607, 1'b0));
      send_tick(fill_tick(-8388608, 1'b1));
      send_tick(fill_tick(4095 * 256, 1'b0));
      drain_pipe();
      write_limit(0);
      send_tick(fill_tick(8388607, 1'b1));
      send_tick(fill_tick(-8388608, 1'b0));
      send_tick(lane_tick(12, 13, -13, -38, -39, 255, -256, 1, 1'b0));
      drain_pipe();
      write_limit(3276);
      send_tick(fill_tick(8388607, 1'b0));
      send_tick(fill_tick(-8388608, 1'b1));
      send_tick(fill_tick(3276 * 256, 1'b1));
      send_tick(fill_tick(-3276 * 256, 1'b0));

      // random bursts under each limit and idle pattern
      for (int p = 0; p < 8; p++) begin
         drain_pipe();
         case (p)
            0: write_limit(3276);
            1: write_limit(0);
            2: write_limit(4095);
            3: write_limit(LimitReset);
            4: write_limit($urandom_range(3276));
            5: write_limit(1);
            6: write_limit($urandom_range(4095));
            default: write_limit(3276);
         endcase
         case (p % 4)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 88;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 88;
            end
            default: begin
               idle_pct = 25;
               stall_pct = 25;
            end
         endcase
         sent = 0;
         while (sent < PhaseItems) begin
            if ($urandom_range(99) < 80) begin
               len = $urandom_range(48, 1);
               if (len > PhaseItems - sent) len = PhaseItems - sent;
               fault = ($urandom_range(99) < 55);
               repeat (len) begin
                  send_tick(random_tick(cur_limit, fault));
                  sent++;
               end
               if ($urandom_range(99) < 5) drain_pipe();
            end else begin
               len = $urandom_range(6, 1);
               if (len > PhaseItems - sent) len = PhaseItems - sent;
               repeat (len) begin
                  send_tick(noise_tick());
                  sent++;
               end
            end
         end
      end

      drain_pipe();
      repeat (8) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("tb_fault_trace_capture: done, clean");
      end else begin
         $display("tb_fault_trace_capture: done, errors");
      end
      $finish;
   end

endmodule
